[sv/versioned_range_add_sum_store_macros.svh]
// Assertion macros shared by the versioned range-add / range-sum store.
// Included by modules that assert; expects clk_i and rst_ni in scope.
`ifndef VERSIONED_RANGE_ADD_SUM_STORE_MACROS_SVH
`define VERSIONED_RANGE_ADD_SUM_STORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define VRS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/vrs_pkg.sv]
// Shared types and codes for the versioned range-add / range-sum store.
// No dependencies; used by vrs_walker and the top level.
package vrs_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUM  = 2'd2,
    CMD_INIT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNINIT      = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_BAD_RANGE   = 3'd3,
    ST_BAD_VERSION = 3'd4,
    ST_OVERFLOW    = 3'd5,
    ST_FULL        = 3'd6,
    ST_TOO_LONG    = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    WALK_BUILD = 2'd0,
    WALK_COPY  = 2'd1,
    WALK_QUERY = 2'd2
  } walk_mode_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [63:0] item_value;
    logic [3:0]         range_left;
    logic [3:0]         range_right;
    logic [5:0]         version_sel;
    logic               load_last;
  } vrs_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         new_version;
    logic signed [63:0] range_total;
  } vrs_out_t;

  typedef struct packed {
    logic       go;
    walk_mode_e mode;
    logic       wr;
  } walk_ctl_t;

  typedef struct packed {
    logic done;
    logic ok;
  } walk_rsp_t;

endpackage

[sv/versioned_range_add_sum_store.sv]
// Versioned range-add / range-sum store. Takes one command beat when start is
// high and busy is low, and answers every command with exactly one result beat
// on res_o, marked by done_o for a single cycle; the receiver cannot stall it.
// Load values, initialize and commands rejected by a check answer one cycle
// after the beat. Other work walks the segment tree one frame step per cycle
// against a node memory with one read and one write port, so with n the array
// size: a range add visits all 2n-1 nodes; the final load value walks the tree
// twice, once to check overflow and once to write; a range sum visits only the
// nodes it splits, reads whole or skips. busy stays high until the result beat.
// Memory contents are not cleared at reset; only slots of existing versions are
// ever read.
module versioned_range_add_sum_store import vrs_pkg::*; #(
  parameter int unsigned MAX_SIZE     = 16,
  parameter int unsigned MAX_VERSIONS = 64,
  parameter int unsigned VALUE_WIDTH  = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  vrs_in_t  req_i,
  output logic     done_o,
  output vrs_out_t res_o
);

`include "versioned_range_add_sum_store_macros.svh"

  localparam int unsigned NPV = 2 * MAX_SIZE - 1;
  localparam int unsigned AW  = $clog2(MAX_VERSIONS * NPV);
  localparam int unsigned PW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CW  = $clog2(MAX_SIZE + 1);
  localparam int unsigned VCW = $clog2(MAX_VERSIONS + 1);

  typedef enum logic [2:0] {P_IDLE, P_CHECK, P_BUILD, P_ADD, P_SUM} phase_e;

  phase_e         ph_q, ph_d;
  logic           busy_q, busy_d, done_q, done_d;
  vrs_out_t       res_q, res_d;
  logic [VCW-1:0] vc_q, vc_d;
  logic [CW-1:0]  size_q, lcnt_q, n_q;
  logic [CW-1:0]  size_d, lcnt_d, n_d;
  logic [PW-1:0]  ql_q, qr_q, ql_d, qr_d;
  logic [AW-1:0]  srcb_q, dstb_q, srcb_d, dstb_d;
  logic [VALUE_WIDTH-1:0] delta_q, delta_d;
  walk_ctl_t      ctl_q, ctl_d;

  walk_rsp_t              wrsp;
  logic [VALUE_WIDTH-1:0] wsum;

  logic acc, bad_range, ld_room, ld_we;

  assign acc       = start && !busy_q;
  assign bad_range = (req_i.range_left > req_i.range_right) ||
                     (32'(req_i.range_right) >= 32'(size_q));
  assign ld_room   = 32'(lcnt_q) < MAX_SIZE;
  assign ld_we     = acc && (req_i.cmd == CMD_LOAD) && ld_room;

  vrs_walker #(
    .MAX_SIZE    (MAX_SIZE),
    .MAX_VERSIONS(MAX_VERSIONS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_q),
    .n_i       (n_q),
    .src_base_i(srcb_q),
    .dst_base_i(dstb_q),
    .ql_i      (ql_q),
    .qr_i      (qr_q),
    .delta_i   (delta_q),
    .ld_we_i   (ld_we),
    .ld_addr_i (PW'(lcnt_q)),
    .ld_data_i (req_i.item_value[VALUE_WIDTH-1:0]),
    .rsp_o     (wrsp),
    .sum_o     (wsum)
  );

  always_comb begin
    ph_d    = ph_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    res_d   = res_q;
    vc_d    = vc_q;
    size_d  = size_q;
    lcnt_d  = lcnt_q;
    n_d     = n_q;
    ql_d    = ql_q;
    qr_d    = qr_q;
    srcb_d  = srcb_q;
    dstb_d  = dstb_q;
    delta_d = delta_q;
    ctl_d   = ctl_q;
    ctl_d.go = 1'b0;
    if (acc) begin
      res_d   = '{status: ST_OK, new_version: '0, range_total: '0};
      ql_d    = PW'(req_i.range_left);
      qr_d    = PW'(req_i.range_right);
      delta_d = req_i.item_value[VALUE_WIDTH-1:0];
      unique case (cmd_e'(req_i.cmd))
        CMD_LOAD: begin
          if (!ld_room) begin
            res_d.status = ST_TOO_LONG;
            lcnt_d = '0;
            done_d = 1'b1;
          end else if (req_i.load_last) begin
            // check the whole tree for overflow before touching version 0
            n_d    = lcnt_q + 1'b1;
            lcnt_d = '0;
            dstb_d = '0;
            srcb_d = '0;
            ctl_d  = '{go: 1'b1, mode: WALK_BUILD, wr: 1'b0};
            ph_d   = P_CHECK;
            busy_d = 1'b1;
          end else begin
            lcnt_d = lcnt_q + 1'b1;
            done_d = 1'b1;
          end
        end
        CMD_INIT: begin
          vc_d   = VCW'(1);
          size_d = '0;
          lcnt_d = '0;
          done_d = 1'b1;
        end
        CMD_ADD: begin
          if (vc_q == '0) begin
            res_d.status = ST_UNINIT;
            done_d = 1'b1;
          end else if (size_q == '0) begin
            res_d.status = ST_EMPTY;
            done_d = 1'b1;
          end else if (bad_range) begin
            res_d.status = ST_BAD_RANGE;
            done_d = 1'b1;
          end else if (32'(vc_q) >= MAX_VERSIONS) begin
            res_d.status = ST_FULL;
            done_d = 1'b1;
          end else begin
            n_d    = size_q;
            srcb_d = AW'(32'(vc_q - 1'b1) * NPV);
            dstb_d = AW'(32'(vc_q) * NPV);
            ctl_d  = '{go: 1'b1, mode: WALK_COPY, wr: 1'b1};
            ph_d   = P_ADD;
            busy_d = 1'b1;
          end
        end
        CMD_SUM: begin
          if (vc_q == '0) begin
            res_d.status = ST_UNINIT;
            done_d = 1'b1;
          end else if (32'(req_i.version_sel) >= 32'(vc_q)) begin
            res_d.status = ST_BAD_VERSION;
            done_d = 1'b1;
          end else if (size_q == '0) begin
            res_d.status = ST_EMPTY;
            done_d = 1'b1;
          end else if (bad_range) begin
            res_d.status = ST_BAD_RANGE;
            done_d = 1'b1;
          end else begin
            n_d    = size_q;
            srcb_d = AW'(32'(req_i.version_sel) * NPV);
            dstb_d = '0;
            ctl_d  = '{go: 1'b1, mode: WALK_QUERY, wr: 1'b0};
            ph_d   = P_SUM;
            busy_d = 1'b1;
          end
        end
        default: done_d = 1'b1;
      endcase
    end else if (wrsp.done) begin
      unique case (ph_q)
        P_CHECK: begin
          if (wrsp.ok) begin
            ctl_d = '{go: 1'b1, mode: WALK_BUILD, wr: 1'b1};
            ph_d  = P_BUILD;
          end else begin
            res_d.status = ST_OVERFLOW;
            ph_d   = P_IDLE;
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        P_BUILD: begin
          vc_d   = VCW'(1);
          size_d = n_q;
          ph_d   = P_IDLE;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        P_ADD: begin
          if (wrsp.ok) begin
            res_d.new_version = 6'(vc_q);
            vc_d = vc_q + 1'b1;
          end else begin
            res_d.status = ST_OVERFLOW;
          end
          ph_d   = P_IDLE;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        P_SUM: begin
          if (wrsp.ok) begin
            res_d.range_total = 64'($signed(wsum));
          end else begin
            res_d.status = ST_OVERFLOW;
          end
          ph_d   = P_IDLE;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: ph_d = P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= P_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
      vc_q    <= '0;
      size_q  <= '0;
      lcnt_q  <= '0;
      n_q     <= '0;
      ql_q    <= '0;
      qr_q    <= '0;
      srcb_q  <= '0;
      dstb_q  <= '0;
      delta_q <= '0;
      ctl_q   <= '{go: 1'b0, mode: WALK_BUILD, wr: 1'b0};
    end else begin
      ph_q    <= ph_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      res_q   <= res_d;
      vc_q    <= vc_d;
      size_q  <= size_d;
      lcnt_q  <= lcnt_d;
      n_q     <= n_d;
      ql_q    <= ql_d;
      qr_q    <= qr_d;
      srcb_q  <= srcb_d;
      dstb_q  <= dstb_d;
      delta_q <= delta_d;
      ctl_q   <= ctl_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  `VRS_ASSERT_NOW(a_done_idle, done_q, !busy_q, "result beat while still busy")
  `VRS_ASSERT_NEXT(a_accept_moves, start && !busy_q, busy_q || done_q, "accepted beat dropped")
  `VRS_ASSERT_NOW(a_walk_owned, wrsp.done, busy_q && (ph_q != P_IDLE), "walker done while idle")
  `VRS_ASSERT_NOW(a_vc_bound, 1'b1, 32'(vc_q) <= MAX_VERSIONS, "version count past limit")

endmodule

[sv/vrs_walker.sv]
// Tree walker: node-sum memory, load buffer and a frame stack that visits
// the segment tree in midpoint split order. Depends on vrs_pkg.
module vrs_walker import vrs_pkg::*; #(
  parameter int unsigned MAX_SIZE     = 16,
  parameter int unsigned MAX_VERSIONS = 64,
  parameter int unsigned VALUE_WIDTH  = 64,
  localparam int unsigned NPV   = 2 * MAX_SIZE - 1,
  localparam int unsigned DEPTH = MAX_VERSIONS * NPV,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned PW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
  localparam int unsigned CW    = $clog2(MAX_SIZE + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  walk_ctl_t              ctl_i,
  input  logic [CW-1:0]          n_i,
  input  logic [AW-1:0]          src_base_i,
  input  logic [AW-1:0]          dst_base_i,
  input  logic [PW-1:0]          ql_i,
  input  logic [PW-1:0]          qr_i,
  input  logic [VALUE_WIDTH-1:0] delta_i,
  input  logic                   ld_we_i,
  input  logic [PW-1:0]          ld_addr_i,
  input  logic [VALUE_WIDTH-1:0] ld_data_i,
  output walk_rsp_t              rsp_o,
  output logic [VALUE_WIDTH-1:0] sum_o
);

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned NW  = $clog2(NPV + 1);
  localparam int unsigned SD  = PW + 2;
  localparam int unsigned SIW = $clog2(SD);
  localparam int unsigned SPW = $clog2(SD + 1);

  typedef enum logic [1:0] {W_IDLE, W_CALL, W_WAIT, W_RET} wstate_e;

  function automatic logic [VW:0] add_ovf(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW-1:0] s;
    s = a + b;
    return {(a[VW-1] == b[VW-1]) && (s[VW-1] != a[VW-1]), s};
  endfunction

  wstate_e        st_q, st_d;
  logic [SPW-1:0] sp_q, sp_d;
  walk_mode_e     mode_q;
  logic           wr_q, ok_q, ok_d;
  logic [VW-1:0]  ret_q, ret_d;

  logic [PW-1:0] fl_q   [SD];
  logic [PW-1:0] fr_q   [SD];
  logic [NW-1:0] fb_q   [SD];
  logic          fph_q  [SD];
  logic [VW-1:0] facc_q [SD];

  logic [VW-1:0] mem_q [DEPTH];
  logic [VW-1:0] ld_q  [MAX_SIZE];
  logic [VW-1:0] mem_rd_q, ld_rd_q;

  logic [SIW-1:0] tix, pix;
  logic [PW-1:0]  t_l, t_r, span, half, mid;
  logic [NW-1:0]  t_b, node_off, rbase;
  logic           disjoint, covered, writing;
  logic [VW:0]    leaf_add, node_add;
  logic [VW-1:0]  leaf_val;

  logic          push_en, top_upd, top_ph_d;
  logic [PW-1:0] push_l, push_r;
  logic [NW-1:0] push_b;
  logic [VW-1:0] top_acc_d;
  logic          mem_re, mem_we, ld_re;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [VW-1:0] mem_wdata;

  assign tix      = SIW'(sp_q - 1'b1);
  assign pix      = SIW'(sp_q);
  assign t_l      = fl_q[tix];
  assign t_r      = fr_q[tix];
  assign t_b      = fb_q[tix];
  assign span     = t_r - t_l;
  assign half     = span >> 1;
  assign mid      = t_l + half;
  assign node_off = t_b + NW'({span, 1'b0});
  assign rbase    = t_b + NW'({half, 1'b1});
  assign disjoint = (t_r < ql_i) || (t_l > qr_i);
  assign covered  = (ql_i <= t_l) && (t_r <= qr_i);
  assign writing  = (mode_q == WALK_COPY) || ((mode_q == WALK_BUILD) && wr_q);
  assign leaf_val = (mode_q == WALK_BUILD) ? ld_rd_q : mem_rd_q;
  assign leaf_add = add_ovf(leaf_val, delta_i);
  assign node_add = add_ovf(facc_q[tix], ret_q);

  always_comb begin
    st_d      = st_q;
    sp_d      = sp_q;
    ok_d      = ok_q;
    ret_d     = ret_q;
    push_en   = 1'b0;
    push_l    = t_l;
    push_r    = mid;
    push_b    = t_b;
    top_upd   = 1'b0;
    top_ph_d  = 1'b0;
    top_acc_d = ret_q;
    mem_re    = 1'b0;
    ld_re     = 1'b0;
    mem_raddr = src_base_i + AW'(node_off);
    mem_we    = 1'b0;
    mem_waddr = dst_base_i + AW'(node_off);
    mem_wdata = ret_q;
    unique case (st_q)
      W_IDLE: begin
        if (ctl_i.go) begin
          push_en = 1'b1;
          push_l  = '0;
          push_r  = PW'(n_i - 1'b1);
          push_b  = '0;
          sp_d    = SPW'(1);
          ok_d    = 1'b1;
          st_d    = W_CALL;
        end
      end
      W_CALL: begin
        if (mode_q == WALK_QUERY && disjoint) begin
          ret_d = '0;
          sp_d  = sp_q - 1'b1;
          st_d  = W_RET;
        end else if ((mode_q == WALK_QUERY && covered) ||
                     (mode_q != WALK_QUERY && span == '0)) begin
          mem_re = (mode_q != WALK_BUILD);
          ld_re  = (mode_q == WALK_BUILD);
          st_d   = W_WAIT;
        end else begin
          // split: left child first
          top_upd  = 1'b1;
          top_ph_d = 1'b0;
          top_acc_d = facc_q[tix];
          push_en  = 1'b1;
          sp_d     = sp_q + 1'b1;
        end
      end
      W_WAIT: begin
        ret_d = leaf_val;
        if (mode_q == WALK_COPY && covered) begin
          ret_d = leaf_add[VW-1:0];
          if (leaf_add[VW]) ok_d = 1'b0;
        end
        mem_we    = writing;
        mem_wdata = ret_d;
        sp_d      = sp_q - 1'b1;
        st_d      = W_RET;
      end
      W_RET: begin
        if (sp_q == '0) begin
          st_d = W_IDLE;
        end else if (!fph_q[tix]) begin
          top_upd   = 1'b1;
          top_ph_d  = 1'b1;
          top_acc_d = ret_q;
          push_en   = 1'b1;
          push_l    = mid + 1'b1;
          push_r    = t_r;
          push_b    = rbase;
          sp_d      = sp_q + 1'b1;
          st_d      = W_CALL;
        end else begin
          ret_d = node_add[VW-1:0];
          if (node_add[VW]) ok_d = 1'b0;
          mem_we    = writing;
          mem_wdata = node_add[VW-1:0];
          sp_d      = sp_q - 1'b1;
        end
      end
      default: st_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= W_IDLE;
      sp_q   <= '0;
      ok_q   <= 1'b1;
      ret_q  <= '0;
      mode_q <= WALK_BUILD;
      wr_q   <= 1'b0;
    end else begin
      st_q  <= st_d;
      sp_q  <= sp_d;
      ok_q  <= ok_d;
      ret_q <= ret_d;
      if (st_q == W_IDLE && ctl_i.go) begin
        mode_q <= ctl_i.mode;
        wr_q   <= ctl_i.wr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      fl_q[pix] <= push_l;
      fr_q[pix] <= push_r;
      fb_q[pix] <= push_b;
    end
    if (top_upd) begin
      fph_q[tix]  <= top_ph_d;
      facc_q[tix] <= top_acc_d;
    end
  end

  // Copies read the source slot and write the destination slot, builds read
  // the load buffer: no access pair ever hits the same entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_we_i) ld_q[ld_addr_i] <= ld_data_i;
    if (ld_re) ld_rd_q <= ld_q[t_l];
  end

  assign rsp_o.done = (st_q == W_RET) && (sp_q == '0);
  assign rsp_o.ok   = ok_q;
  assign sum_o      = ret_q;

endmodule

[tb/versioned_range_add_sum_store_tb.sv]
// Testbench for the versioned range-add / range-sum store: drives command beats
// and checks every result beat against a behavioral model of the version store.
// Depends on vrs_pkg and the versioned_range_add_sum_store top level.
`timescale 1ns / 100ps

module versioned_range_add_sum_store_tb;
  import vrs_pkg::*;

  localparam int unsigned ARR_MAX = 16;
  localparam int unsigned VER_MAX = 64;

  class store_scoreboard;
    logic signed [63:0] elems [VER_MAX][ARR_MAX];
    logic signed [63:0] pend [ARR_MAX];
    int unsigned n_ver, n_elem, n_pend;
    vrs_out_t expq [$];
    int unsigned errors;

    function new();
      n_ver = 0; n_elem = 0; n_pend = 0; errors = 0;
    endfunction

    function automatic bit add_ovf(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      return (a[63] == b[63]) && (s[63] != a[63]);
    endfunction

    // Sum subtree [l,r] bottom-up in midpoint split order, over a leaf array.
    function automatic logic signed [63:0] tree_total(logic signed [63:0] lv [ARR_MAX],
                                                      int l, int r, ref bit ok);
      logic signed [63:0] a, b;
      int m;
      if (l == r) return lv[l];
      m = l + (r - l) / 2;
      a = tree_total(lv, l, m, ok);
      b = tree_total(lv, m + 1, r, ok);
      if (add_ovf(a, b)) ok = 0;
      return a + b;
    endfunction

    function automatic logic signed [63:0] range_total(logic signed [63:0] lv [ARR_MAX],
                                                       int l, int r, int ql, int qr,
                                                       ref bit ok);
      logic signed [63:0] a, b;
      int m;
      bit dummy;
      if (r < ql || l > qr) return 0;
      if (ql <= l && r <= qr) begin
        dummy = 1;
        return tree_total(lv, l, r, dummy);
      end
      m = l + (r - l) / 2;
      a = range_total(lv, l, m, ql, qr, ok);
      b = range_total(lv, m + 1, r, ql, qr, ok);
      if (add_ovf(a, b)) ok = 0;
      return a + b;
    endfunction

    function void note_command(vrs_in_t c);
      vrs_out_t r;
      logic signed [63:0] lv [ARR_MAX];
      bit ok;
      r = '0;
      ok = 1;
      r.status = ST_OK;
      case (cmd_e'(c.cmd))
        CMD_LOAD: begin
          if (n_pend >= ARR_MAX) begin
            r.status = ST_TOO_LONG;
            n_pend = 0;
          end else begin
            pend[n_pend] = c.item_value;
            n_pend++;
            if (c.load_last) begin
              void'(tree_total(pend, 0, n_pend - 1, ok));
              if (!ok) r.status = ST_OVERFLOW;
              else begin
                elems[0] = pend;
                n_ver = 1;
                n_elem = n_pend;
              end
              n_pend = 0;
            end
          end
        end
        CMD_INIT: begin
          n_ver = 1; n_elem = 0; n_pend = 0;
        end
        CMD_ADD: begin
          if (n_ver == 0) r.status = ST_UNINIT;
          else if (n_elem == 0) r.status = ST_EMPTY;
          else if (c.range_left > c.range_right || c.range_right >= n_elem)
            r.status = ST_BAD_RANGE;
          else if (n_ver >= VER_MAX) r.status = ST_FULL;
          else begin
            lv = elems[n_ver - 1];
            if (c.item_value != 0) begin
              for (int i = c.range_left; i <= c.range_right; i++) begin
                if (add_ovf(lv[i], c.item_value)) ok = 0;
                lv[i] = lv[i] + c.item_value;
              end
              void'(tree_total(lv, 0, n_elem - 1, ok));
            end
            if (!ok) r.status = ST_OVERFLOW;
            else begin
              elems[n_ver] = lv;
              r.new_version = 6'(n_ver);
              n_ver++;
            end
          end
        end
        default: begin
          if (n_ver == 0) r.status = ST_UNINIT;
          else if (c.version_sel >= n_ver) r.status = ST_BAD_VERSION;
          else if (n_elem == 0) r.status = ST_EMPTY;
          else if (c.range_left > c.range_right || c.range_right >= n_elem)
            r.status = ST_BAD_RANGE;
          else begin
            lv = elems[c.version_sel];
            r.range_total = range_total(lv, 0, n_elem - 1, c.range_left,
                                        c.range_right, ok);
            if (!ok) begin
              r.status = ST_OVERFLOW;
              r.range_total = '0;
            end
          end
        end
      endcase
      expq = {expq, r};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(vrs_out_t got);
      vrs_out_t want;
      if (expq.size() == 0) begin
        report("unexpected result beat", 64'(got.status), 64'd0);
        return;
      end
      want = expq.pop_front();
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
      if (got.new_version !== want.new_version)
        report("new_version", 64'(got.new_version), 64'(want.new_version));
      if (got.range_total !== want.range_total)
        report("range_total", got.range_total, want.range_total);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy, done_o;
  vrs_in_t req_i = '0;
  vrs_out_t res_o;
  int unsigned idle_pct = 14;
  store_scoreboard sb;

  versioned_range_add_sum_store dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .res_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  // Hold start between back-to-back beats; drop it only while idling.
  task automatic send_beat(vrs_in_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    req_i <= c;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expq.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [63:0] rand_value();
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = 0;
      1: v = $signed(64'($urandom_range(20))) - 10;
      2: v = {1'b0, {63{1'b1}}} - $urandom_range(3);
      3: v = {1'b1, 63'b0} + $urandom_range(3);
      4: v = $signed(v) >>> 40;
      default: ;
    endcase
    return v;
  endfunction

  function automatic vrs_in_t mk(cmd_e c, logic signed [63:0] v, int l, int r,
                                 int ver, bit last);
    vrs_in_t x;
    x.cmd = c; x.item_value = v; x.range_left = 4'(l); x.range_right = 4'(r);
    x.version_sel = 6'(ver); x.load_last = last;
    return x;
  endfunction

  task automatic load_array(int n, bit big);
    for (int i = 0; i < n; i++)
      send_beat(mk(CMD_LOAD, big ? rand_value() : $signed(64'($urandom_range(2000))) - 1000,
                   $urandom, $urandom, $urandom, i == n - 1));
  endtask

  task automatic random_beat();
    int l, r, k;
    l = $urandom_range(15);
    r = $urandom_range(15);
    if ($urandom_range(3) != 0 && sb.n_elem > 0) begin
      r = $urandom_range(sb.n_elem - 1);
      l = $urandom_range(r);
    end
    k = $urandom_range(99);
    if (k < 35)
      send_beat(mk(CMD_ADD, $urandom_range(3) == 0 ? rand_value() :
                   $signed(64'($urandom_range(200))) - 100, l, r, $urandom, $urandom));
    else if (k < 85)
      send_beat(mk(CMD_SUM, $urandom, l, r,
                   $urandom_range(3) == 0 ? $urandom_range(63) :
                   $urandom_range(sb.n_ver == 0 ? 0 : sb.n_ver - 1), $urandom));
    else if (k < 90)
      send_beat(mk(CMD_LOAD, rand_value(), l, r, $urandom, $urandom_range(3) == 0));
    else if (k < 92)
      send_beat(mk(CMD_INIT, $urandom, l, r, $urandom, $urandom));
    else
      load_array($urandom_range(1, 16), $urandom_range(3) == 0);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: uninitialized, empty, too long, overflow, extremes, full.
    send_beat(mk(CMD_ADD, 1, 0, 0, 0, 0));
    send_beat(mk(CMD_SUM, 0, 0, 0, 0, 0));
    send_beat(mk(CMD_INIT, 0, 0, 0, 0, 0));
    send_beat(mk(CMD_ADD, 5, 0, 0, 0, 0));
    send_beat(mk(CMD_SUM, 0, 0, 0, 0, 0));
    send_beat(mk(CMD_SUM, 0, 0, 0, 63, 1));
    load_array(17, 0);
    send_beat(mk(CMD_LOAD, {1'b0, {63{1'b1}}}, 0, 0, 0, 0));
    send_beat(mk(CMD_LOAD, 1, 0, 0, 0, 1));
    send_beat(mk(CMD_LOAD, {1'b1, 63'b0}, 15, 15, 63, 0));
    send_beat(mk(CMD_LOAD, {1'b0, {63{1'b1}}}, 15, 15, 63, 1));
    send_beat(mk(CMD_ADD, 0, 0, 1, 0, 0));
    send_beat(mk(CMD_ADD, -1, 0, 0, 0, 0));
    send_beat(mk(CMD_ADD, 3, 1, 0, 0, 0));
    send_beat(mk(CMD_ADD, 3, 0, 2, 0, 0));
    send_beat(mk(CMD_SUM, 0, 0, 1, 2, 0));
    send_beat(mk(CMD_SUM, 0, 0, 1, 1, 0));
    load_array(16, 0);
    for (int i = 0; i < 64; i++) send_beat(mk(CMD_ADD, i + 1, i % 16, 15, 0, 0));
    send_beat(mk(CMD_SUM, 0, 0, 15, 63, 0));
    // Hold off until the block has drained.
    drain();
    @(posedge clk_i);
    load_array(5, 0);
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = ph == 0 ? 14 : (ph == 1 ? 49 : 0);
      for (int i = 0; i < 80; i++) begin
        if (sb.n_ver >= VER_MAX && $urandom_range(1)) load_array($urandom_range(1, 16), 0);
        random_beat();
      end
    end
    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.expq.size() == 0)
      $display("versioned_range_add_sum_store_tb: PASS");
    else
      $display("versioned_range_add_sum_store_tb: FAIL");
    $finish;
  end

  initial begin
    #8000000;
    $display("versioned_range_add_sum_store_tb: FAIL");
    $finish;
  end
endmodule

[versioned_range_add_sum_store.f]
+incdir+sv
sv/vrs_pkg.sv
sv/vrs_walker.sv
sv/versioned_range_add_sum_store.sv
tb/versioned_range_add_sum_store_tb.sv
